/* hdl/mlfq_pkg.sv */
// Shared package for the multilevel feedback queue scheduler.
// Holds the default parameter values, opcode and status codes and the command type.
// No dependencies; every other file of the block but mlfq_ram imports it.
package mlfq_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_NUM_SLOTS   = 16;
    localparam int DEF_NUM_LEVELS  = 64;
    localparam int DEF_FRAC_BITS   = 14;
    localparam int DEF_SLICE_TICKS = 4;

    // Configuration register.
    localparam int              TPS_W     = 10;
    localparam logic [TPS_W-1:0] TPS_RESET = 10'd100;

    // Stream widths.
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 56;

    // Event opcodes.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_UNBLOCK = 3'd2;
    localparam logic [2:0] OP_YIELD   = 3'd3;
    localparam logic [2:0] OP_BLOCK   = 3'd4;
    localparam logic [2:0] OP_EXIT    = 3'd5;
    localparam logic [2:0] OP_NICE    = 3'd6;
    localparam logic [2:0] OP_QUERY   = 3'd7;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_NICE = 2'd1;
    localparam logic [1:0] STAT_BAD_SLOT = 2'd2;

    // Thread slot states.
    localparam logic [1:0] SS_FREE    = 2'd0;
    localparam logic [1:0] SS_BLOCKED = 2'd1;
    localparam logic [1:0] SS_READY   = 2'd2;
    localparam logic [1:0] SS_RUNNING = 2'd3;

    // Classified event as it travels from the front end to the engine.
    typedef struct packed {
        logic [2:0]        op;
        logic [3:0]        slot;
        logic              slot_ok;
        logic signed [5:0] nice;
        logic              nice_ok;
    } t_cmd;

endpackage

/* hdl/mlfq_thread_scheduler.sv */
// Top level of the multilevel feedback queue thread scheduler.
// Depends on mlfq_pkg, mlfq_front and mlfq_core (which uses mlfq_ram).
//
// Usage: events enter on the s_axis channel (opcode in tuser, slot and nice in
// tdata) and every event produces exactly one result transfer on m_axis.
// ticks_per_second is written through i_cfg_wen/i_cfg_wdata while no event is
// in flight.
// A front queue of two events feeds an engine that runs one event at a time.
// Every event passes the decode and the result states; a push onto a level,
// a dispatch from the highest level and a create add their own sequencer
// states. A tick that closes a time slice recomputes priority and requeues
// every slot, and the once-per-second update runs the bit-serial divider and
// then steps through the slot tables; the next event enters the engine only
// after this one is done.
// Reset clears all slots to free, empties every level, selects idle and loads
// ticks_per_second with 100. The engine holds a finished result in its output
// register while the receiver stalls and waits there; the front queue keeps
// accepting until its two entries are full.
module mlfq_thread_scheduler #(
    parameter int NUM_SLOTS   = mlfq_pkg::DEF_NUM_SLOTS,
    parameter int NUM_LEVELS  = mlfq_pkg::DEF_NUM_LEVELS,
    parameter int FRAC_BITS   = mlfq_pkg::DEF_FRAC_BITS,
    parameter int SLICE_TICKS = mlfq_pkg::DEF_SLICE_TICKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: slot [3:0], nice_value [9:4], zero fill above.
    input  logic [mlfq_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: opcode [2:0].
    input  logic [mlfq_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: running_slot [3:0], running_idle [4], preempt [5], status [7:6],
    // running_priority [13:8], running_nice [19:14], load_x100 [30:20],
    // cpu_x100 [55:31].
    output logic [mlfq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                             i_cfg_wen,
    input  logic [mlfq_pkg::TPS_W-1:0]       i_cfg_wdata
);
    import mlfq_pkg::*;

    logic [TPS_W-1:0] r_tps;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;

    // Ticks-per-second configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_wen) begin
            r_tps <= i_cfg_wdata;
        end
    end

    mlfq_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_ready     (cmd_ready)
    );

    mlfq_core #(
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_LEVELS  (NUM_LEVELS),
        .FRAC_BITS   (FRAC_BITS),
        .SLICE_TICKS (SLICE_TICKS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tps           (r_tps),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_ready     (cmd_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

/* hdl/mlfq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mlfq_front.sv */
// Front end of the scheduler: accepts events, classifies them and queues them.
// Depends on mlfq_pkg for the command type and stream widths.
module mlfq_front #(
    parameter int NUM_SLOTS = mlfq_pkg::DEF_NUM_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: slot [3:0], nice_value [9:4], zero fill above.
    input  logic [mlfq_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: opcode [2:0].
    input  logic [mlfq_pkg::IN_TUSER_W-1:0] i_s_axis_tuser,
    output logic                            o_cmd_valid,
    output mlfq_pkg::t_cmd                  o_cmd,
    input  logic                            i_cmd_ready
);
    import mlfq_pkg::*;

    t_cmd       n_cmd;
    t_cmd       r_fifo [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    // Classify the incoming event: range checks on slot and nice.
    always_comb begin
        n_cmd.op      = i_s_axis_tuser[2:0];
        n_cmd.slot    = i_s_axis_tdata[3:0];
        n_cmd.slot_ok = (9'(i_s_axis_tdata[3:0]) < 9'(NUM_SLOTS));
        n_cmd.nice    = signed'(i_s_axis_tdata[9:4]);
        n_cmd.nice_ok = (n_cmd.nice >= -6'sd20) && (n_cmd.nice <= 6'sd20);
    end

    assign o_s_axis_tready = (r_cnt != 2'd2);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid     = (r_cnt != 2'd0);
    assign pop             = o_cmd_valid && i_cmd_ready;
    assign o_cmd           = r_fifo[r_rp];

    // Two-entry queue toward the engine.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

/* hdl/mlfq_core.sv */
// Scheduling engine: runs one classified event at a time through a sequencer
// over the slot tables, the level queues and the load average, then registers the result.
// Depends on mlfq_pkg and mlfq_ram (level head and tail memories).
module mlfq_core #(
    parameter int NUM_SLOTS   = mlfq_pkg::DEF_NUM_SLOTS,
    parameter int NUM_LEVELS  = mlfq_pkg::DEF_NUM_LEVELS,
    parameter int FRAC_BITS   = mlfq_pkg::DEF_FRAC_BITS,
    parameter int SLICE_TICKS = mlfq_pkg::DEF_SLICE_TICKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [mlfq_pkg::TPS_W-1:0]       i_tps,
    input  logic                             i_cmd_valid,
    input  mlfq_pkg::t_cmd                   i_cmd,
    output logic                             o_cmd_ready,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: running_slot [3:0], running_idle [4], preempt [5], status [7:6],
    // running_priority [13:8], running_nice [19:14], load_x100 [30:20],
    // cpu_x100 [55:31].
    output logic [mlfq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import mlfq_pkg::*;

    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int CW  = $clog2(NUM_SLOTS + 1);
    localparam int KW  = $clog2(SLICE_TICKS + 1);
    localparam int LDW = 32;
    localparam int RW  = LDW + 3;
    localparam int PW  = FRAC_BITS + 33;
    localparam int MW  = LDW + 7;
    localparam int DCW = $clog2(FRAC_BITS + 1);

    localparam logic signed [39:0] HALF40 = 40'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE64  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] MAX32  = 64'sd2147483647;
    localparam logic signed [63:0] MIN32  = -64'sd2147483648;
    localparam logic [RW-1:0]      ONE_R  = RW'(1) << FRAC_BITS;
    localparam logic [MW-1:0]      HALF_M = MW'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS-1:0] C59  = FRAC_BITS'((59 * (1 << FRAC_BITS)) / 60);
    localparam logic [FRAC_BITS-1:0] C1   = FRAC_BITS'((1 << FRAC_BITS) / 60);

    // Sequencer states.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DEC     = 5'd1;
    localparam logic [4:0] S_T1      = 5'd2;
    localparam logic [4:0] S_RC_EVAL = 5'd3;
    localparam logic [4:0] S_RC_NEXT = 5'd4;
    localparam logic [4:0] S_TPH     = 5'd5;
    localparam logic [4:0] S_SEC0    = 5'd6;
    localparam logic [4:0] S_SEC1    = 5'd7;
    localparam logic [4:0] S_SEC2    = 5'd8;
    localparam logic [4:0] S_DIV     = 5'd9;
    localparam logic [4:0] S_SU_EVAL = 5'd10;
    localparam logic [4:0] S_SU_WR   = 5'd11;
    localparam logic [4:0] S_SU_NEXT = 5'd12;
    localparam logic [4:0] S_TEND    = 5'd13;
    localparam logic [4:0] S_CR1     = 5'd14;
    localparam logic [4:0] S_CR2     = 5'd15;
    localparam logic [4:0] S_PU0     = 5'd16;
    localparam logic [4:0] S_PU1     = 5'd17;
    localparam logic [4:0] S_DS0     = 5'd18;
    localparam logic [4:0] S_DS1     = 5'd19;
    localparam logic [4:0] S_DS2     = 5'd20;
    localparam logic [4:0] S_O0      = 5'd21;
    localparam logic [4:0] S_O1      = 5'd22;
    localparam logic [4:0] S_O2      = 5'd23;

    // Priority from recent cpu and nice, rounded and clamped to the level range.
    function automatic logic [LW-1:0] f_prio(input logic signed [31:0] rc,
                                             input logic signed [5:0] nv);
        logic signed [39:0] v;
        logic signed [39:0] r;
        v = (40'(NUM_LEVELS - 1) <<< FRAC_BITS) - 40'(rc >>> 2)
            - (40'(nv) <<< (FRAC_BITS + 1));
        if (v >= 0) begin
            r = (v + HALF40) >>> FRAC_BITS;
        end else begin
            r = -((HALF40 - v) >>> FRAC_BITS);
        end
        if (r < 0) begin
            r = '0;
        end else if (r > 40'(NUM_LEVELS - 1)) begin
            r = 40'(NUM_LEVELS - 1);
        end
        return LW'(r);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFFFFFF;
        end else if (v < MIN32) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // Highest set bit of the level occupancy vector.
    function automatic logic [LW-1:0] f_top(input logic [NUM_LEVELS-1:0] ne);
        logic [LW-1:0] p;
        p = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (ne[i]) begin
                p = LW'(i);
            end
        end
        return p;
    endfunction

    // Slot tables.
    logic signed [31:0] r_rc   [NUM_SLOTS];
    logic signed [5:0]  r_nice [NUM_SLOTS];
    logic [LW-1:0]      r_prio [NUM_SLOTS];
    logic [1:0]         r_stat [NUM_SLOTS];
    logic [SW-1:0]      r_nxt  [NUM_SLOTS];

    // Scheduler state and sequencer registers.
    logic [4:0]            r_state;
    logic [4:0]            r_ret;
    t_cmd                  r_cmd;
    logic [1:0]            r_status;
    logic [SW-1:0]         r_ix;
    logic [SW-1:0]         r_ps;
    logic [LW-1:0]         r_pp;
    logic [SW-1:0]         r_cur;
    logic                  r_idle;
    logic [NUM_LEVELS-1:0] r_ne;
    logic [CW-1:0]         r_rdy;
    logic [KW-1:0]         r_slice;
    logic [TPS_W-1:0]      r_phase;
    logic [LDW-1:0]        r_load;
    logic [LDW+FRAC_BITS-1:0] r_mul;
    logic [RW-1:0]         r_rem;
    logic [RW-1:0]         r_den;
    logic [FRAC_BITS-1:0]  r_q;
    logic [DCW-1:0]        r_dcnt;
    logic signed [PW-1:0]  r_prod;
    logic signed [31:0]    r_trc;
    logic signed [5:0]     r_tn;
    logic [MW-1:0]         r_m1;
    logic signed [38:0]    r_m2;
    logic                  r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    // Table read port, always at r_ix.
    logic signed [31:0] rd_rc;
    logic signed [5:0]  rd_nice;
    logic [LW-1:0]      rd_prio;
    logic [1:0]         rd_stat;

    assign rd_rc   = r_rc[r_ix];
    assign rd_nice = r_nice[r_ix];
    assign rd_prio = r_prio[r_ix];
    assign rd_stat = r_stat[r_ix];

    // Level head and tail memories, both addressed by r_pp.
    logic          head_we;
    logic          tail_we;
    logic [SW-1:0] head_wd;
    logic [SW-1:0] head_rd;
    logic [SW-1:0] tail_rd;

    assign head_we = ((r_state == S_PU0) && !r_ne[r_pp])
                   || ((r_state == S_DS2) && (head_rd != tail_rd));
    assign head_wd = (r_state == S_PU0) ? r_ps : r_nxt[head_rd];
    assign tail_we = ((r_state == S_PU0) && !r_ne[r_pp]) || (r_state == S_PU1);

    mlfq_ram #(.WIDTH(SW), .DEPTH(NUM_LEVELS)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_pp),
        .i_wdata (head_wd),
        .i_raddr (r_pp),
        .o_rdata (head_rd)
    );

    mlfq_ram #(.WIDTH(SW), .DEPTH(NUM_LEVELS)) u_tail (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (r_pp),
        .i_wdata (r_ps),
        .i_raddr (r_pp),
        .o_rdata (tail_rd)
    );

    // Links between queued slots.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PU1) begin
            r_nxt[tail_rd] <= r_ps;
        end
    end

    // Combinational helpers for the sequencer.
    logic [LW-1:0]     n_newp;
    logic [CW-1:0]     n_rdy_dec;
    logic [TPS_W:0]    n_phase;
    logic [RW-1:0]     n_rem2;
    logic [MW-1:0]     n_ld_full;
    logic [10:0]       n_ld;
    logic signed [38:0] n_rc_full;
    logic [24:0]       n_rcx;
    logic              n_preempt;
    logic [OUT_TDATA_W-1:0] n_odata;

    always_comb begin
        n_newp    = f_prio(rd_rc, r_cmd.nice);
        n_rdy_dec = (r_rdy != '0) ? (r_rdy - CW'(1)) : r_rdy;
        n_phase   = {1'b0, r_phase} + (TPS_W + 1)'(1);
        n_rem2    = r_rem << 1;

        // Load average times 100, rounded and saturated.
        n_ld_full = (r_m1 + HALF_M) >> FRAC_BITS;
        n_ld      = (n_ld_full > MW'(2047)) ? 11'h7FF : 11'(n_ld_full);

        // Recent cpu times 100, rounded half away from zero and saturated; zero when idle.
        if (r_m2 >= 0) begin
            n_rc_full = (r_m2 + 39'(HALF40)) >>> FRAC_BITS;
        end else begin
            n_rc_full = -((39'(HALF40) - r_m2) >>> FRAC_BITS);
        end
        if (r_idle) begin
            n_rcx = '0;
        end else if (n_rc_full > 39'sd16777215) begin
            n_rcx = 25'h0FFFFFF;
        end else if (n_rc_full < -39'sd16777216) begin
            n_rcx = 25'h1000000;
        end else begin
            n_rcx = 25'(n_rc_full);
        end

        n_preempt = (r_slice >= KW'(SLICE_TICKS));
        n_odata   = {n_rcx, n_ld,
                     r_idle ? 6'd0 : 6'(rd_nice),
                     r_idle ? 6'd0 : 6'(rd_prio),
                     r_status, n_preempt, r_idle, 4'(r_cur)};
    end

    assign o_cmd_ready     = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Event sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rc[i]   <= '0;
                r_nice[i] <= '0;
                r_prio[i] <= '0;
                r_stat[i] <= SS_FREE;
            end
            r_state  <= S_IDLE;
            r_ret    <= S_O0;
            r_status <= STAT_OK;
            r_ix     <= '0;
            r_cur    <= '0;
            r_idle   <= 1'b1;
            r_ne     <= '0;
            r_rdy    <= '0;
            r_slice  <= '0;
            r_phase  <= '0;
            r_load   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // The result register empties on its transfer unless a new result loads it.
            if (r_ovalid && i_m_axis_tready && (r_state != S_O2)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_status <= STAT_OK;
                        if ((i_cmd.op == OP_CREATE) || (i_cmd.op == OP_UNBLOCK)) begin
                            r_ix <= SW'(i_cmd.slot);
                        end else begin
                            r_ix <= r_cur;
                        end
                        r_state <= S_DEC;
                    end
                end

                S_DEC: begin
                    case (r_cmd.op)
                        OP_TICK: begin
                            if (!r_idle) begin
                                r_rc[r_ix] <= f_sat32(64'(rd_rc) + ONE64);
                            end
                            r_state <= S_T1;
                        end
                        OP_CREATE: begin
                            if (!r_cmd.slot_ok || (rd_stat != SS_FREE)) begin
                                r_status <= STAT_BAD_SLOT;
                                r_state  <= S_O0;
                            end else begin
                                r_ix    <= r_cur;
                                r_state <= S_CR1;
                            end
                        end
                        OP_UNBLOCK: begin
                            if (!r_cmd.slot_ok || (rd_stat != SS_BLOCKED)) begin
                                r_status <= STAT_BAD_SLOT;
                                r_state  <= S_O0;
                            end else begin
                                r_ps    <= r_ix;
                                r_pp    <= rd_prio;
                                r_rdy   <= r_rdy + CW'(1);
                                r_ret   <= S_O0;
                                r_state <= S_PU0;
                            end
                        end
                        OP_YIELD: begin
                            if (!r_idle) begin
                                r_ps    <= r_ix;
                                r_pp    <= rd_prio;
                                r_ret   <= S_DS0;
                                r_state <= S_PU0;
                            end else begin
                                r_state <= S_DS0;
                            end
                        end
                        OP_BLOCK: begin
                            if (!r_idle) begin
                                r_stat[r_ix] <= SS_BLOCKED;
                                r_rdy        <= n_rdy_dec;
                            end
                            r_state <= S_DS0;
                        end
                        OP_EXIT: begin
                            if (r_idle) begin
                                r_status <= STAT_BAD_SLOT;
                                r_state  <= S_O0;
                            end else begin
                                r_stat[r_ix] <= SS_FREE;
                                r_rdy        <= n_rdy_dec;
                                r_state      <= S_DS0;
                            end
                        end
                        OP_NICE: begin
                            if (!r_cmd.nice_ok) begin
                                r_status <= STAT_BAD_NICE;
                                r_state  <= S_O0;
                            end else if (r_idle) begin
                                r_status <= STAT_BAD_SLOT;
                                r_state  <= S_O0;
                            end else begin
                                r_nice[r_ix] <= r_cmd.nice;
                                r_prio[r_ix] <= n_newp;
                                // Give way when a higher occupied level now outranks this thread.
                                if ((rd_prio > n_newp) && (((r_ne >> n_newp) >> 1) != '0)) begin
                                    r_ps    <= r_ix;
                                    r_pp    <= n_newp;
                                    r_ret   <= S_DS0;
                                    r_state <= S_PU0;
                                end else begin
                                    r_state <= S_O0;
                                end
                            end
                        end
                        default: begin
                            r_state <= S_O0;
                        end
                    endcase
                end

                // Create: copy nice and recent cpu from the running thread (zero when idle).
                S_CR1: begin
                    r_tn    <= r_idle ? 6'sd0 : rd_nice;
                    r_trc   <= r_idle ? 32'sd0 : rd_rc;
                    r_ix    <= SW'(r_cmd.slot);
                    r_state <= S_CR2;
                end

                S_CR2: begin
                    r_nice[r_ix] <= r_tn;
                    r_rc[r_ix]   <= r_trc;
                    r_prio[r_ix] <= f_prio(r_trc, r_tn);
                    r_ps         <= r_ix;
                    r_pp         <= f_prio(r_trc, r_tn);
                    r_rdy        <= r_rdy + CW'(1);
                    r_ret        <= S_O0;
                    r_state      <= S_PU0;
                end

                // Tick: end of slice starts a recompute over all slots.
                S_T1: begin
                    if (r_slice == KW'(SLICE_TICKS - 1)) begin
                        r_ne    <= '0;
                        r_ix    <= '0;
                        r_state <= S_RC_EVAL;
                    end else begin
                        r_state <= S_TPH;
                    end
                end

                S_RC_EVAL: begin
                    if (rd_stat != SS_FREE) begin
                        r_prio[r_ix] <= f_prio(rd_rc, rd_nice);
                    end
                    if (rd_stat == SS_READY) begin
                        r_ps    <= r_ix;
                        r_pp    <= f_prio(rd_rc, rd_nice);
                        r_ret   <= S_RC_NEXT;
                        r_state <= S_PU0;
                    end else begin
                        r_state <= S_RC_NEXT;
                    end
                end

                S_RC_NEXT: begin
                    if (r_ix == SW'(NUM_SLOTS - 1)) begin
                        r_state <= S_TPH;
                    end else begin
                        r_ix    <= r_ix + SW'(1);
                        r_state <= S_RC_EVAL;
                    end
                end

                // Tick phase: once per second update load and recent cpu.
                S_TPH: begin
                    if (n_phase >= {1'b0, i_tps}) begin
                        r_phase <= '0;
                        r_state <= S_SEC0;
                    end else begin
                        r_phase <= TPS_W'(n_phase);
                        r_state <= S_TEND;
                    end
                end

                S_SEC0: begin
                    r_mul   <= (LDW + FRAC_BITS)'(C59) * (LDW + FRAC_BITS)'(r_load);
                    r_state <= S_SEC1;
                end

                S_SEC1: begin
                    r_load  <= LDW'(r_mul >> FRAC_BITS) + LDW'(C1) * LDW'(r_rdy);
                    r_state <= S_SEC2;
                end

                // Decay coefficient 2*load / (2*load + 1) by restoring division.
                S_SEC2: begin
                    r_rem   <= RW'({r_load, 1'b0});
                    r_den   <= RW'({r_load, 1'b0}) + ONE_R;
                    r_q     <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    if (n_rem2 >= r_den) begin
                        r_rem <= n_rem2 - r_den;
                        r_q   <= {r_q[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem2;
                        r_q   <= {r_q[FRAC_BITS-2:0], 1'b0};
                    end
                    if (r_dcnt == DCW'(FRAC_BITS - 1)) begin
                        r_ix    <= '0;
                        r_state <= S_SU_EVAL;
                    end else begin
                        r_dcnt <= r_dcnt + DCW'(1);
                    end
                end

                S_SU_EVAL: begin
                    if (rd_stat != SS_FREE) begin
                        r_prod  <= signed'({1'b0, r_q}) * rd_rc;
                        r_state <= S_SU_WR;
                    end else begin
                        r_state <= S_SU_NEXT;
                    end
                end

                S_SU_WR: begin
                    r_rc[r_ix] <= f_sat32(64'(r_prod >>> FRAC_BITS)
                                          + (64'(rd_nice) <<< FRAC_BITS));
                    r_state    <= S_SU_NEXT;
                end

                S_SU_NEXT: begin
                    if (r_ix == SW'(NUM_SLOTS - 1)) begin
                        r_state <= S_TEND;
                    end else begin
                        r_ix    <= r_ix + SW'(1);
                        r_state <= S_SU_EVAL;
                    end
                end

                S_TEND: begin
                    if (r_slice < KW'(SLICE_TICKS)) begin
                        r_slice <= r_slice + KW'(1);
                    end
                    r_state <= S_O0;
                end

                // Push r_ps onto the tail of level r_pp.
                S_PU0: begin
                    if (r_ne[r_pp]) begin
                        r_state <= S_PU1;
                    end else begin
                        r_ne[r_pp]   <= 1'b1;
                        r_stat[r_ps] <= SS_READY;
                        r_state      <= r_ret;
                    end
                end

                S_PU1: begin
                    r_stat[r_ps] <= SS_READY;
                    r_state      <= r_ret;
                end

                // Dispatch the head of the highest occupied level.
                S_DS0: begin
                    r_slice <= '0;
                    if (r_ne == '0) begin
                        r_idle  <= 1'b1;
                        r_cur   <= '0;
                        r_state <= S_O0;
                    end else begin
                        r_pp    <= f_top(r_ne);
                        r_state <= S_DS1;
                    end
                end

                S_DS1: begin
                    r_state <= S_DS2;
                end

                S_DS2: begin
                    r_cur           <= head_rd;
                    r_idle          <= 1'b0;
                    r_stat[head_rd] <= SS_RUNNING;
                    if (head_rd == tail_rd) begin
                        r_ne[r_pp] <= 1'b0;
                    end
                    r_state <= S_O0;
                end

                // Result formatting and hand-off to the output register.
                S_O0: begin
                    r_ix    <= r_cur;
                    r_state <= S_O1;
                end

                S_O1: begin
                    r_m1    <= MW'(r_load) * MW'(100);
                    r_m2    <= 39'(rd_rc) * 39'sd100;
                    r_state <= S_O2;
                end

                S_O2: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_odata  <= n_odata;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/mlfq_thread_scheduler_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the multilevel feedback queue thread scheduler.
// Depends on mlfq_pkg and the mlfq_thread_scheduler RTL; it holds its own scheduler predictor.
module mlfq_thread_scheduler_tb;
    import mlfq_pkg::*;

    localparam int  SLOTS  = 16;
    localparam int  LEVELS = 64;
    localparam int  FRAC   = 14;
    localparam int  SLICE  = 4;
    localparam int  IDLE_SLOT = SLOTS;
    localparam longint FX  = longint'(1) << FRAC;

    // One result transfer, split into its fields.
    typedef struct {
        int slot;
        int idle;
        int preempt;
        int status;
        int prio;
        int nice;
        int load_x100;
        int rc_x100;
    } t_sched_result;

    // Scheduler predictor and the queue of results it still waits for.
    class sched_scoreboard;
        int            rc_tab[SLOTS];
        int            nice_tab[SLOTS];
        int            prio_tab[SLOTS];
        logic [1:0]    state_tab[SLOTS];
        int            next_tab[SLOTS];
        int            head_tab[LEVELS];
        int            tail_tab[LEVELS];
        bit [63:0]     nonempty;
        longint        load_fx;
        int            ready_cnt;
        int            running;
        int            slice_cnt;
        int            phase_cnt;
        int            tps;
        int            errors;
        t_sched_result awaited[$];

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                rc_tab[s] = 0;
                nice_tab[s] = 0;
                prio_tab[s] = 0;
                state_tab[s] = SS_FREE;
                next_tab[s] = 0;
            end
            for (int p = 0; p < LEVELS; p++) begin
                head_tab[p] = 0;
                tail_tab[p] = 0;
            end
            nonempty = '0;
            load_fx = 0;
            ready_cnt = 0;
            running = IDLE_SLOT;
            slice_cnt = 0;
            phase_cnt = 0;
            tps = int'(TPS_RESET);
            errors = 0;
        endfunction

        function longint round_fx(longint x);
            return (x >= 0) ? (x + FX / 2) / FX : (x - FX / 2) / FX;
        endfunction

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7fffffff;
            if (v < -64'sd2147483648) return 32'h80000000;
            return int'(v);
        endfunction

        function int priority_of(int s);
            longint v;
            longint p;
            v = (LEVELS - 1) * FX - (longint'(rc_tab[s]) >>> 2)
                - longint'(2 * nice_tab[s]) * FX;
            p = round_fx(v);
            if (p < 0) p = 0;
            if (p > LEVELS - 1) p = LEVELS - 1;
            return int'(p);
        endfunction

        function void enqueue(int s);
            int p;
            p = prio_tab[s];
            if (nonempty[p]) next_tab[tail_tab[p]] = s;
            else head_tab[p] = s;
            tail_tab[p] = s;
            nonempty[p] = 1'b1;
            state_tab[s] = SS_READY;
        endfunction

        // Pop the head of the highest non-empty level, or fall back to idle.
        function void pick_next();
            int s;
            running = IDLE_SLOT;
            for (int p = LEVELS - 1; p >= 0; p--) begin
                if (nonempty[p]) begin
                    s = head_tab[p];
                    if (s == tail_tab[p]) nonempty[p] = 1'b0;
                    else head_tab[p] = next_tab[s];
                    running = s;
                    state_tab[s] = SS_RUNNING;
                    break;
                end
            end
            slice_cnt = 0;
        endfunction

        function void requeue_all();
            nonempty = '0;
            for (int s = 0; s < SLOTS; s++) begin
                if (state_tab[s] != SS_FREE) begin
                    prio_tab[s] = priority_of(s);
                    if (state_tab[s] == SS_READY) enqueue(s);
                end
            end
        endfunction

        function void per_second();
            longint c59;
            longint c1;
            longint twice;
            longint coef;
            c59 = (59 * FX) / 60;
            c1 = FX / 60;
            load_fx = ((c59 * load_fx) >>> FRAC)
                    + ((c1 * (longint'(ready_cnt) * FX)) >>> FRAC);
            twice = 2 * load_fx;
            coef = (twice * FX) / (twice + FX);
            for (int s = 0; s < SLOTS; s++) begin
                if (state_tab[s] != SS_FREE)
                    rc_tab[s] = sat32(((coef * longint'(rc_tab[s])) >>> FRAC)
                                      + longint'(nice_tab[s]) * FX);
            end
        endfunction

        function void set_rate(int value);
            tps = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted event and queue the result it must produce.
        function void note_event(logic [2:0] op, logic [3:0] slot, logic signed [5:0] nv);
            t_sched_result r;
            int     cur;
            int     stat;
            int     oldp;
            int     newp;
            bit     idle;
            longint v;
            idle = (running >= SLOTS);
            cur = idle ? 0 : running;
            stat = STAT_OK;
            case (op)
                OP_TICK: begin
                    if (!idle) rc_tab[cur] = sat32(longint'(rc_tab[cur]) + FX);
                    if (slice_cnt + 1 == SLICE) requeue_all();
                    phase_cnt++;
                    if (phase_cnt >= tps) begin
                        phase_cnt = 0;
                        per_second();
                    end
                    if (slice_cnt < SLICE) slice_cnt++;
                end
                OP_CREATE: begin
                    if (state_tab[slot] != SS_FREE) begin
                        stat = STAT_BAD_SLOT;
                    end else begin
                        nice_tab[slot] = idle ? 0 : nice_tab[cur];
                        rc_tab[slot] = idle ? 0 : rc_tab[cur];
                        prio_tab[slot] = priority_of(slot);
                        enqueue(slot);
                        ready_cnt++;
                    end
                end
                OP_UNBLOCK: begin
                    if (state_tab[slot] != SS_BLOCKED) begin
                        stat = STAT_BAD_SLOT;
                    end else begin
                        enqueue(slot);
                        ready_cnt++;
                    end
                end
                OP_YIELD: begin
                    if (!idle) enqueue(cur);
                    pick_next();
                end
                OP_BLOCK: begin
                    if (!idle) begin
                        state_tab[cur] = SS_BLOCKED;
                        if (ready_cnt > 0) ready_cnt--;
                    end
                    pick_next();
                end
                OP_EXIT: begin
                    if (idle) begin
                        stat = STAT_BAD_SLOT;
                    end else begin
                        state_tab[cur] = SS_FREE;
                        if (ready_cnt > 0) ready_cnt--;
                        pick_next();
                    end
                end
                OP_NICE: begin
                    if (nv < -20 || nv > 20) begin
                        stat = STAT_BAD_NICE;
                    end else if (idle) begin
                        stat = STAT_BAD_SLOT;
                    end else begin
                        oldp = prio_tab[cur];
                        nice_tab[cur] = int'(nv);
                        newp = priority_of(cur);
                        prio_tab[cur] = newp;
                        // A thread that lost priority gives way to a higher ready level.
                        if (oldp > newp && newp + 1 < LEVELS && (nonempty >> (newp + 1)) != 0) begin
                            enqueue(cur);
                            pick_next();
                        end
                    end
                end
                default: begin
                end
            endcase

            idle = (running >= SLOTS);
            cur = idle ? 0 : running;
            r.slot = cur;
            r.idle = idle;
            r.preempt = (slice_cnt >= SLICE);
            r.status = stat;
            r.prio = idle ? 0 : prio_tab[cur];
            r.nice = idle ? 0 : nice_tab[cur];
            v = round_fx(load_fx * 100);
            if (v < 0) v = 0;
            if (v > 2047) v = 2047;
            r.load_x100 = int'(v);
            if (idle) begin
                v = 0;
            end else begin
                v = round_fx(longint'(rc_tab[cur]) * 100);
                if (v > 16777215) v = 16777215;
                if (v < -16777216) v = -16777216;
            end
            r.rc_x100 = int'(v);
            awaited.push_back(r);
        endfunction

        function void report(string what, int got, int want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endfunction

        // Compare one result transfer against the oldest expectation.
        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_sched_result w;
            if (awaited.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            w = awaited.pop_front();
            if (int'(d[3:0]) != w.slot) report("running_slot", d[3:0], w.slot);
            if (int'(d[4]) != w.idle) report("running_idle", d[4], w.idle);
            if (int'(d[5]) != w.preempt) report("preempt", d[5], w.preempt);
            if (int'(d[7:6]) != w.status) report("status", d[7:6], w.status);
            if (int'(d[13:8]) != w.prio) report("running_priority", d[13:8], w.prio);
            if (int'($signed(d[19:14])) != w.nice)
                report("running_nice", $signed(d[19:14]), w.nice);
            if (int'(d[30:20]) != w.load_x100) report("load x100", d[30:20], w.load_x100);
            if (int'($signed(d[55:31])) != w.rc_x100)
                report("cpu x100", $signed(d[55:31]), w.rc_x100);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_wen;
    logic [TPS_W-1:0]       i_cfg_wdata;

    sched_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    mlfq_thread_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stalls at random on each falling edge.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
    end

    // Offer one event and wait for its transfer; called and returning at a falling edge.
    task automatic send_event(logic [2:0] op, logic [3:0] slot, logic signed [5:0] nv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = op;
        i_s_axis_tdata = {6'b0, nv, slot};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_event(op, slot, nv);
        @(negedge i_clk);
    endtask

    // Wait for every outstanding result, then let the engine settle.
    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_rate(int value);
        i_cfg_wen = 1'b1;
        i_cfg_wdata = value[TPS_W-1:0];
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
        sb.set_rate(value);
    endtask

    // Random event mix, weighted toward ticks so slices and seconds roll over.
    task automatic send_random();
        int          w;
        logic [2:0]  op;
        logic signed [5:0] nv;
        w = $urandom_range(0, 99);
        if (w < 35) op = OP_TICK;
        else if (w < 50) op = OP_CREATE;
        else if (w < 60) op = OP_UNBLOCK;
        else if (w < 70) op = OP_YIELD;
        else if (w < 78) op = OP_BLOCK;
        else if (w < 85) op = OP_EXIT;
        else if (w < 95) op = OP_NICE;
        else op = OP_QUERY;
        if ($urandom_range(0, 99) < 85) nv = 6'($signed($urandom_range(0, 40)) - 20);
        else nv = 6'($urandom_range(0, 63));
        send_event(op, 4'($urandom_range(0, 15)), nv);
    endtask

    // Run limit.
    initial begin
        #100ms;
        $display("mlfq_thread_scheduler regression: fail");
        $finish;
    end

    // Main sequence.
    initial begin
        int rates[6];
        sb = new();
        rates = '{19, 0, 1000, 1023, 60, 3};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = OP_QUERY;
        i_cfg_wen = 1'b0;
        i_cfg_wdata = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: idle corner cases, nice limits, creation and dispatch.
        send_event(OP_QUERY, 4'd0, 6'sd0);
        send_event(OP_EXIT, 4'd0, 6'sd0);
        send_event(OP_NICE, 4'd0, 6'sd5);
        send_event(OP_NICE, 4'd0, 6'sd31);
        send_event(OP_NICE, 4'd0, -6'sd32);
        send_event(OP_BLOCK, 4'd0, 6'sd0);
        send_event(OP_YIELD, 4'd0, 6'sd0);
        send_event(OP_UNBLOCK, 4'd7, 6'sd0);
        send_event(OP_CREATE, 4'd0, 6'sd0);
        send_event(OP_CREATE, 4'd15, 6'sd0);
        send_event(OP_CREATE, 4'd0, 6'sd0);
        send_event(OP_YIELD, 4'd0, 6'sd0);
        repeat (5) send_event(OP_TICK, 4'd0, 6'sd0);
        send_event(OP_NICE, 4'd0, -6'sd20);
        send_event(OP_CREATE, 4'd3, 6'sd0);
        send_event(OP_NICE, 4'd0, 6'sd20);
        send_event(OP_BLOCK, 4'd0, 6'sd0);
        send_event(OP_UNBLOCK, 4'd0, 6'sd0);
        send_event(OP_EXIT, 4'd0, 6'sd0);
        send_event(OP_QUERY, 4'd15, -6'sd1);
        drain();

        // Random phases, each under its own update period; pairs of phases share an idling pattern.
        for (int ph = 0; ph < 6; ph++) begin
            write_rate(rates[ph]);
            if (ph < 2) begin
                send_idle_pct = 20;
                recv_idle_pct = 70;
            end else if (ph < 4) begin
                send_idle_pct = 70;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (210) send_random();
            drain();
        end

        if (sb.errors == 0) begin
            $display("mlfq_thread_scheduler regression: pass");
        end else begin
            $display("mlfq_thread_scheduler regression: fail");
        end
        $finish;
    end

endmodule
